// ===== src/lhs_pkg.sv =====
package lhs_pkg;

    // field widths of the request and result channels
    localparam int OP_W     = 2;
    localparam int SAMPLE_W = 32;
    localparam int CNT_W    = 32;
    localparam int TOTAL_W  = 48;
    localparam int P99_W    = 10;

    // divider operand widths
    localparam int DIV_NW = 48;
    localparam int DIV_DW = 32;

    // percentile ratio
    localparam int PCT_NUM = 99;
    localparam int PCT_DEN = 100;

    // floor(c / PCT_DEN) equals (c * PCT_RECIP) >> PCT_SHIFT for any 32-bit c
    localparam logic [CNT_W-1:0] PCT_RECIP = 32'h51EB_851F;
    localparam int               PCT_SHIFT = 37;

    // request operation codes
    localparam logic [OP_W-1:0] OP_RECORD = 2'd0;
    localparam logic [OP_W-1:0] OP_REPORT = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

endpackage

// ===== src/lhs_in_if.sv =====
interface lhs_in_if;
    import lhs_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [SAMPLE_W-1:0] sample_ms;

    modport source (output valid, op, sample_ms, input ready);
    modport sink   (input valid, op, sample_ms, output ready);
endinterface

// ===== src/lhs_out_if.sv =====
interface lhs_out_if;
    import lhs_pkg::*;

    logic                valid;
    logic                ready;
    logic                has_samples;
    logic [CNT_W-1:0]    sample_count;
    logic [TOTAL_W-1:0]  total_ms;
    logic [SAMPLE_W-1:0] min_ms;
    logic [SAMPLE_W-1:0] max_ms;
    logic [SAMPLE_W-1:0] avg_ms;
    logic [P99_W-1:0]    p99_bucket;

    modport source (
        output valid, has_samples, sample_count, total_ms, min_ms, max_ms, avg_ms, p99_bucket,
        input  ready
    );
    modport sink (
        input  valid, has_samples, sample_count, total_ms, min_ms, max_ms, avg_ms, p99_bucket,
        output ready
    );
endinterface

// ===== src/lhs_ram.sv =====
module lhs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/lhs_div.sv =====
module lhs_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [lhs_pkg::DIV_NW-1:0] i_dividend,
    input  logic [lhs_pkg::DIV_DW-1:0] i_divisor,
    output logic                      o_done,
    output logic [lhs_pkg::DIV_NW-1:0] o_quotient
);
    import lhs_pkg::*;

    localparam int STEP_W = $clog2(DIV_NW);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_div;
    logic [DIV_NW-1:0] r_quo;
    logic [DIV_DW:0]   n_trial;
    logic              n_bit;

    // one restoring step: shift in the next dividend bit and try to subtract
    always_comb begin
        n_trial = {r_rem, r_quo[DIV_NW-1]};
        n_bit   = (n_trial >= {1'b0, r_div});
        if (n_bit) begin
            n_trial = n_trial - {1'b0, r_div};
        end
    end

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(DIV_NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_trial[DIV_DW-1:0];
            r_quo <= {r_quo[DIV_NW-2:0], n_bit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

// ===== src/latency_histogram_stats_unit.sv =====
// Latency statistics collector with a BUCKETS-entry histogram held in one
// single-read, single-write RAM. On a record request the bucket is read in
// the cycle of the transfer and the incremented count is written back in
// the next, as the histogram RAM read is registered. Count, total, min and
// max live in flops and update with the transfer. A report request forms
// the percentile target ceil(count*99/100) as count - count/100 from a
// 32x32 reciprocal product registered at the transfer, then one pass of a
// bit-serial 48/32 divider gives the average, and a walk over the
// histogram reads one bucket per cycle until the running sum reaches the
// target; with no samples it skips the target, divider and walk. A clear
// request, and likewise reset, starts a clearing pass that writes one
// bucket per cycle, during which no request is taken. The result sits in an
// output register, so record and clear requests keep flowing while a report
// waits to be taken.
module latency_histogram_stats_unit #(
    parameter int BUCKETS = 1024
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    lhs_in_if.sink   i_req,
    lhs_out_if.source o_res
);
    import lhs_pkg::*;

    localparam int IW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int CW = CNT_W + IW;
    localparam int XW = (IW > P99_W) ? IW : P99_W;
    localparam logic [IW-1:0] LAST = IW'(BUCKETS - 1);

    typedef enum logic [6:0] {
        S_CLR   = 7'b000_0001,
        S_IDLE  = 7'b000_0010,
        S_RECWR = 7'b000_0100,
        S_TGT   = 7'b000_1000,
        S_AVG_W = 7'b001_0000,
        S_WALK  = 7'b010_0000,
        S_OUT   = 7'b100_0000
    } t_state;

    t_state r_state, n_state;

    // statistics registers
    logic [CNT_W-1:0]    r_count;
    logic [TOTAL_W-1:0]  r_total;
    logic [SAMPLE_W-1:0] r_min;
    logic [SAMPLE_W-1:0] r_max;

    // sequencing
    logic [IW-1:0] r_ca;
    logic          r_pv;
    logic          r_ov;

    // report datapath
    logic [IW-1:0]       r_bidx;
    logic [2*CNT_W-1:0]  r_num;
    logic [CNT_W-1:0]    r_target;
    logic [SAMPLE_W-1:0] r_avg;
    logic [CW-1:0]       r_cum;
    logic [IW:0]         r_ra;
    logic [IW-1:0]       r_pi;
    logic [IW-1:0]       r_p99;
    logic                r_has;

    // result register
    logic                r_o_has;
    logic [CNT_W-1:0]    r_o_count;
    logic [TOTAL_W-1:0]  r_o_total;
    logic [SAMPLE_W-1:0] r_o_min;
    logic [SAMPLE_W-1:0] r_o_max;
    logic [SAMPLE_W-1:0] r_o_avg;
    logic [P99_W-1:0]    r_o_p99;

    logic                accept;
    logic [IW-1:0]       in_bidx;
    logic [TOTAL_W:0]    sum;
    logic                ram_we;
    logic [IW-1:0]       ram_waddr;
    logic [CNT_W-1:0]    ram_wdata;
    logic [IW-1:0]       ram_raddr;
    logic [CNT_W-1:0]    ram_rdata;
    logic                div_start;
    logic [DIV_NW-1:0]   div_dividend;
    logic [DIV_DW-1:0]   div_divisor;
    logic                div_done;
    logic [DIV_NW-1:0]   div_quo;
    logic [CW-1:0]       cum_n;
    logic                walk_issue;
    logic                walk_stop;
    logic                out_load;
    logic [XW-1:0]       p99_ext;

    // input transfer and bucket index, clamped to the last bucket
    assign accept  = i_req.valid && (r_state == S_IDLE);
    assign in_bidx = (i_req.sample_ms < SAMPLE_W'(BUCKETS)) ? i_req.sample_ms[IW-1:0] : LAST;
    assign sum     = {1'b0, r_total} + (TOTAL_W + 1)'(i_req.sample_ms);

    // histogram walk: issue one read a cycle, accumulate in the cycle after
    assign walk_issue = (r_state == S_WALK) && (r_ra < (IW + 1)'(BUCKETS));
    assign cum_n      = r_cum + CW'(ram_rdata);
    assign walk_stop  = (r_state == S_WALK) && r_pv &&
                        ((cum_n >= CW'(r_target)) || (r_pi == LAST));

    assign out_load = (r_state == S_OUT) && (!r_ov || o_res.ready);

    // histogram memory ports
    assign ram_raddr = (r_state == S_WALK) ? r_ra[IW-1:0] : in_bidx;
    assign ram_we    = (r_state == S_RECWR) || (r_state == S_CLR);
    assign ram_waddr = (r_state == S_CLR) ? r_ca : r_bidx;
    assign ram_wdata = (r_state == S_CLR) ? '0 :
                       ((ram_rdata == '1) ? ram_rdata : ram_rdata + 1'b1);

    lhs_ram #(
        .WIDTH (CNT_W),
        .DEPTH (BUCKETS)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // divider for the average
    assign div_start    = (r_state == S_TGT);
    assign div_dividend = DIV_NW'(r_total);
    assign div_divisor  = DIV_DW'(r_count);

    lhs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR: begin
                if (r_ca == LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    unique case (i_req.op)
                        OP_RECORD: n_state = S_RECWR;
                        OP_REPORT: n_state = (r_count != '0) ? S_TGT : S_OUT;
                        OP_CLEAR:  n_state = S_CLR;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_RECWR: n_state = S_IDLE;
            S_TGT:   n_state = S_AVG_W;
            S_AVG_W: begin
                if (div_done) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (walk_stop) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLR;
        endcase
    end

    // control and statistics registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_ca    <= '0;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
            r_count <= '0;
            r_total <= '0;
            r_min   <= '1;
            r_max   <= '0;
        end else begin
            r_state <= n_state;

            // clearing pass address
            if (r_state == S_CLR) begin
                r_ca <= (r_ca == LAST) ? '0 : r_ca + 1'b1;
            end

            // scalar updates on record and clear
            if (accept) begin
                case (i_req.op)
                    OP_RECORD: begin
                        if (r_count != '1) begin
                            r_count <= r_count + 1'b1;
                        end
                        r_total <= sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
                        if (i_req.sample_ms > r_max) begin
                            r_max <= i_req.sample_ms;
                        end
                        if (i_req.sample_ms < r_min) begin
                            r_min <= i_req.sample_ms;
                        end
                    end
                    OP_CLEAR: begin
                        r_count <= '0;
                        r_total <= '0;
                        r_min   <= '1;
                        r_max   <= '0;
                        r_ca    <= '0;
                    end
                    default: begin
                    end
                endcase
            end

            // walk read pipeline valid
            if ((r_state == S_AVG_W) && div_done) begin
                r_pv <= 1'b0;
            end else begin
                r_pv <= walk_issue;
            end

            // output register valid
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign p99_ext = XW'(r_p99);

    // report datapath and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_bidx <= in_bidx;
            r_has  <= (r_count != '0);
            // 32 by 32 reciprocal product for count / 100
            r_num  <= (2*CNT_W)'(r_count) * (2*CNT_W)'(PCT_RECIP);
        end
        // ceil(count * 99 / 100) is count - floor(count / 100)
        if (r_state == S_TGT) begin
            r_target <= r_count - CNT_W'(r_num[2*CNT_W-1:PCT_SHIFT]);
        end
        if ((r_state == S_AVG_W) && div_done) begin
            r_avg <= (|div_quo[DIV_NW-1:SAMPLE_W]) ? '1 : div_quo[SAMPLE_W-1:0];
            r_ra  <= '0;
            r_cum <= '0;
        end
        if (walk_issue) begin
            r_ra <= r_ra + 1'b1;
            r_pi <= r_ra[IW-1:0];
        end
        if ((r_state == S_WALK) && r_pv) begin
            r_cum <= cum_n;
        end
        if (walk_stop) begin
            r_p99 <= r_pi;
        end
        if (out_load) begin
            r_o_has   <= r_has;
            r_o_count <= r_has ? r_count : '0;
            r_o_total <= r_has ? r_total : '0;
            r_o_min   <= r_has ? r_min : '0;
            r_o_max   <= r_has ? r_max : '0;
            r_o_avg   <= r_has ? r_avg : '0;
            r_o_p99   <= r_has ? p99_ext[P99_W-1:0] : '0;
        end
    end

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_res.valid        = r_ov;
    assign o_res.has_samples  = r_o_has;
    assign o_res.sample_count = r_o_count;
    assign o_res.total_ms     = r_o_total;
    assign o_res.min_ms       = r_o_min;
    assign o_res.max_ms       = r_o_max;
    assign o_res.avg_ms       = r_o_avg;
    assign o_res.p99_bucket   = r_o_p99;
endmodule

// ===== src/lhs_checker.sv =====
module lhs_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic [lhs_pkg::OP_W-1:0]      i_in_op,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic                          i_has,
    input logic [lhs_pkg::CNT_W-1:0]     i_count,
    input logic [lhs_pkg::SAMPLE_W-1:0]  i_min,
    input logic [lhs_pkg::SAMPLE_W-1:0]  i_max
);
    import lhs_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // the sample flag agrees with the reported count
    a_has_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_has == (i_count != '0)))
        else $error("sample flag disagrees with count");

    // reported min never exceeds reported max
    a_min_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_has |-> (i_min <= i_max))
        else $error("min above max");

    // the clearing pass after reset holds off requests
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("request taken during clearing pass");

    // a record transfer is followed by its histogram write-back cycle
    a_rec_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_op == OP_RECORD) |=> !i_in_ready)
        else $error("request taken during write-back");
endmodule

bind latency_histogram_stats_unit lhs_checker u_lhs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_in_op     (i_req.op),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_has       (o_res.has_samples),
    .i_count     (o_res.sample_count),
    .i_min       (o_res.min_ms),
    .i_max       (o_res.max_ms)
);
